// ----- src/scc_pkg.sv -----
// scc_pkg: sizes, status codes and controller/datapath command types for the
// sector cache clock replacement block. No dependencies.
package scc_pkg;

    localparam int ENTRIES      = 64;
    localparam int SECTOR_BYTES = 512;
    localparam int IDX_W        = $clog2(ENTRIES);
    localparam int STEP_W       = IDX_W + 1;
    localparam int TAG_W        = 32;
    localparam int WC_W         = 8;
    localparam logic [WC_W-1:0] WC_MAX = {WC_W{1'b1}};

    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_FILL      = 3'd1,
        ST_EVICT     = 3'd2,
        ST_BLOCKED   = 3'd3,
        ST_RELEASED  = 3'd4,
        ST_HANDED    = 3'd5,
        ST_NO_VICTIM = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_TAG_RD,
        CMD_SCAN_NEXT,
        CMD_HIT,
        CMD_FILL,
        CMD_SWEEP,
        CMD_VIC_RD,
        CMD_EVICT,
        CMD_NOVIC,
        CMD_WC_RD,
        CMD_BLOCK,
        CMD_RELEASE,
        CMD_PUSH
    } t_cmd;

    typedef struct packed {
        logic match;
        logic busy_hit;
        logic scan_last;
        logic scan_empty;
        logic victim;
        logic sweep_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- src/scc_if.sv -----
// scc_if: valid/ready channel interfaces for acquire/release requests and results.
// Depends on nothing.
interface scc_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] sector;
    logic        is_write;
    logic [8:0]  sector_offset;
    logic [9:0]  length;
    logic [5:0]  entry_index;

    modport source (output valid, op, sector, is_write, sector_offset, length,
                    entry_index, input ready);
    modport sink (input valid, op, sector, is_write, sector_offset, length,
                  entry_index, output ready);
endinterface

interface scc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [5:0]  slot;
    logic        need_fetch;
    logic        need_writeback;
    logic [31:0] writeback_sector;

    modport source (output valid, status, slot, need_fetch, need_writeback,
                    writeback_sector, input ready);
    modport sink (input valid, status, slot, need_fetch, need_writeback,
                  writeback_sector, output ready);
endinterface

// ----- src/sector_cache_clock_replacement.sv -----
// sector_cache_clock_replacement: top level, joins controller and datapath.
// Depends on scc_pkg, scc_if, scc_ctrl, scc_dp, scc_ram.
//
//   channel  dir  beat contents
//   i_in     in   op, sector, is_write, sector_offset, length, entry_index
//   o_out    out  status, slot, need_fetch, need_writeback, writeback_sector
//
// one request at a time; the tag search reads and compares one tag at a time from the
// tag memory in index order, so a hit on entry k is found after entries 0 to k-1
// a miss scans all entries, then fills the first empty entry or runs the clock
// sweep at one entry a cycle, up to 2*ENTRIES steps, and evicts the victim it finds
// a release reads the waiter count, then updates the entry; input is ready when a result appears
// reset is synchronous and clears all status bits
// a finished result waits in the output register while the next request is taken
module sector_cache_clock_replacement
    import scc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    scc_in_if.sink   i_in,
    scc_out_if.source o_out
);
    t_cmd     w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    assign i_in.ready = w_in_ready;

    scc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_op       (i_in.op),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    scc_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_op               (i_in.op),
        .i_sector           (i_in.sector),
        .i_is_write         (i_in.is_write),
        .i_sector_offset    (i_in.sector_offset),
        .i_length           (i_in.length),
        .i_entry_index      (i_in.entry_index),
        .i_out_ready        (o_out.ready),
        .o_stat             (w_stat),
        .o_out_valid        (o_out.valid),
        .o_status           (o_out.status),
        .o_slot             (o_out.slot),
        .o_need_fetch       (o_out.need_fetch),
        .o_need_writeback   (o_out.need_writeback),
        .o_writeback_sector (o_out.writeback_sector)
    );
endmodule

// ----- src/scc_ram.sv -----
// scc_ram: generic single-write, single-read memory with registered read data.
// No dependencies.
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/scc_ctrl.sv -----
// scc_ctrl: sequencing state machine for tag search, fill, clock sweep and release.
// Depends on scc_pkg.
module scc_ctrl
    import scc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_op,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_cmd     o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_HIT, S_FILL, S_SWEEP, S_VIC_RD,
        S_VIC_WR, S_NOVIC, S_WC_RD, S_BLOCK, S_REL_RD, S_REL_WR, S_FIN
    } t_state;

    t_state r_state, n_state;
    t_cmd   n_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd   = CMD_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = CMD_LOAD;
                    n_state = (i_op == REQ_RELEASE) ? S_REL_RD : S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                n_cmd   = CMD_TAG_RD;
                n_state = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (i_stat.match) begin
                    n_state = i_stat.busy_hit ? S_WC_RD : S_HIT;
                end else begin
                    n_cmd = CMD_SCAN_NEXT;
                    if (i_stat.scan_last) begin
                        n_state = i_stat.scan_empty ? S_FILL : S_SWEEP;
                    end else begin
                        n_state = S_SRCH_RD;
                    end
                end
            end
            S_HIT: begin
                n_cmd   = CMD_HIT;
                n_state = S_FIN;
            end
            S_FILL: begin
                n_cmd   = CMD_FILL;
                n_state = S_FIN;
            end
            S_SWEEP: begin
                n_cmd = CMD_SWEEP;
                if (i_stat.victim) begin
                    n_state = S_VIC_RD;
                end else if (i_stat.sweep_last) begin
                    n_state = S_NOVIC;
                end
            end
            S_VIC_RD: begin
                n_cmd   = CMD_VIC_RD;
                n_state = S_VIC_WR;
            end
            S_VIC_WR: begin
                n_cmd   = CMD_EVICT;
                n_state = S_FIN;
            end
            S_NOVIC: begin
                n_cmd   = CMD_NOVIC;
                n_state = S_FIN;
            end
            S_WC_RD: begin
                n_cmd   = CMD_WC_RD;
                n_state = S_BLOCK;
            end
            S_BLOCK: begin
                n_cmd   = CMD_BLOCK;
                n_state = S_FIN;
            end
            S_REL_RD: begin
                n_cmd   = CMD_WC_RD;
                n_state = S_REL_WR;
            end
            S_REL_WR: begin
                n_cmd   = CMD_RELEASE;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    n_cmd   = CMD_PUSH;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = n_cmd;
endmodule

// ----- src/scc_dp.sv -----
// scc_dp: request registers, per-entry status bits, clock hand, tag and waiter
// memories, result and output registers. Depends on scc_pkg and scc_ram.
module scc_dp
    import scc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_op,
    input  logic [31:0] i_sector,
    input  logic        i_is_write,
    input  logic [8:0]  i_sector_offset,
    input  logic [9:0]  i_length,
    input  logic [5:0]  i_entry_index,
    input  logic        i_out_ready,
    output t_dp_stat    o_stat,
    output logic        o_out_valid,
    output logic [2:0]  o_status,
    output logic [5:0]  o_slot,
    output logic        o_need_fetch,
    output logic        o_need_writeback,
    output logic [31:0] o_writeback_sector
);
    // request
    logic             r_op;
    logic [TAG_W-1:0] r_sector;
    logic             r_wr;
    logic [8:0]       r_ofs;
    logic [9:0]       r_len;
    logic [5:0]       r_entry;
    logic             r_stray;

    // search and sweep
    logic [IDX_W-1:0]  r_idx;
    logic              r_empty_found;
    logic [IDX_W-1:0]  r_empty_idx;
    logic [IDX_W-1:0]  r_hand;
    logic [STEP_W-1:0] r_steps;

    // per-entry status
    logic [ENTRIES-1:0] r_valid, r_dirty, r_used, r_busy, r_nz;

    // pending result and output beat
    t_status     r_res_st;
    logic [5:0]  r_res_slot;
    logic        r_res_fetch, r_res_wb;
    logic [31:0] r_res_wbsec;
    logic        r_ov;
    t_status     r_o_st;
    logic [5:0]  r_o_slot;
    logic        r_o_fetch, r_o_wb;
    logic [31:0] r_o_wbsec;

    logic [IDX_W-1:0] w_rel;
    logic [IDX_W-1:0] w_tag_raddr, w_tag_waddr, w_wc_raddr, w_wc_waddr;
    logic             w_tag_we, w_wc_we;
    logic [TAG_W-1:0] w_tag_rdata;
    logic [WC_W-1:0]  w_wc_rdata, w_wc_wdata, w_wc_cur;
    logic             w_fetch, w_avail;
    logic [IDX_W-1:0] w_hand_inc;

    assign w_rel      = IDX_W'(r_entry);
    assign w_hand_inc = (r_hand == IDX_W'(ENTRIES - 1)) ? '0 : r_hand + 1'b1;
    assign w_fetch    = !r_wr || (r_ofs != 9'd0) || (32'(r_len) < SECTOR_BYTES);
    assign w_avail    = !r_busy[r_hand] && !r_nz[r_hand];

    // a zero waiter flag means the stored count is stale and reads as zero
    assign w_wc_cur = r_nz[w_wc_raddr] ? w_wc_rdata : '0;

    assign w_tag_raddr = (i_cmd == CMD_VIC_RD) ? r_hand : r_idx;
    assign w_tag_we    = (i_cmd == CMD_FILL) || (i_cmd == CMD_EVICT);
    assign w_tag_waddr = (i_cmd == CMD_FILL) ? r_empty_idx : r_hand;
    assign w_wc_raddr  = (r_op == REQ_RELEASE) ? w_rel : r_idx;
    assign w_wc_waddr  = w_wc_raddr;
    assign w_wc_we     = (i_cmd == CMD_BLOCK) ||
                         ((i_cmd == CMD_RELEASE) && !r_stray && r_valid[w_rel]
                          && r_busy[w_rel] && r_nz[w_rel]);
    assign w_wc_wdata  = (i_cmd == CMD_BLOCK) ?
                         ((w_wc_cur == WC_MAX) ? w_wc_cur : w_wc_cur + 1'b1) :
                         w_wc_cur - 1'b1;

    scc_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_tag_we),
        .i_waddr (w_tag_waddr),
        .i_wdata (r_sector),
        .i_raddr (w_tag_raddr),
        .o_rdata (w_tag_rdata)
    );

    scc_ram #(.WIDTH(WC_W), .DEPTH(ENTRIES)) u_wc_ram (
        .i_clk   (i_clk),
        .i_we    (w_wc_we),
        .i_waddr (w_wc_waddr),
        .i_wdata (w_wc_wdata),
        .i_raddr (w_wc_raddr),
        .o_rdata (w_wc_rdata)
    );

    always_comb begin
        o_stat.match      = r_valid[r_idx] && (w_tag_rdata == r_sector);
        o_stat.busy_hit   = r_busy[r_idx];
        o_stat.scan_last  = (r_idx == IDX_W'(ENTRIES - 1));
        o_stat.scan_empty = r_empty_found || !r_valid[r_idx];
        o_stat.victim     = w_avail && !r_used[r_hand];
        o_stat.sweep_last = (r_steps == STEP_W'(2 * ENTRIES - 1));
        o_stat.out_free   = !r_ov || i_out_ready;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_op          <= i_op;
                r_sector      <= i_sector;
                r_wr          <= i_is_write;
                r_ofs         <= i_sector_offset;
                r_len         <= i_length;
                r_entry       <= i_entry_index;
                r_stray       <= (32'(i_entry_index) >= ENTRIES);
                r_idx         <= '0;
                r_steps       <= '0;
                r_empty_found <= 1'b0;
            end
            CMD_SCAN_NEXT: begin
                if (!r_valid[r_idx] && !r_empty_found) begin
                    r_empty_found <= 1'b1;
                    r_empty_idx   <= r_idx;
                end
                r_idx <= r_idx + 1'b1;
            end
            CMD_SWEEP: begin
                r_steps <= r_steps + 1'b1;
            end
            default: ;
        endcase

        case (i_cmd)
            CMD_HIT: begin
                r_res_st    <= ST_HIT;
                r_res_slot  <= 6'(r_idx);
                r_res_fetch <= 1'b0;
                r_res_wb    <= 1'b0;
                r_res_wbsec <= '0;
            end
            CMD_FILL: begin
                r_res_st    <= ST_FILL;
                r_res_slot  <= 6'(r_empty_idx);
                r_res_fetch <= w_fetch;
                r_res_wb    <= 1'b0;
                r_res_wbsec <= '0;
            end
            CMD_EVICT: begin
                r_res_st    <= ST_EVICT;
                r_res_slot  <= 6'(r_hand);
                r_res_fetch <= w_fetch;
                r_res_wb    <= r_dirty[r_hand];
                r_res_wbsec <= r_dirty[r_hand] ? w_tag_rdata : '0;
            end
            CMD_NOVIC: begin
                r_res_st    <= ST_NO_VICTIM;
                r_res_slot  <= '0;
                r_res_fetch <= 1'b0;
                r_res_wb    <= 1'b0;
                r_res_wbsec <= '0;
            end
            CMD_BLOCK: begin
                r_res_st    <= ST_BLOCKED;
                r_res_slot  <= 6'(r_idx);
                r_res_fetch <= 1'b0;
                r_res_wb    <= 1'b0;
                r_res_wbsec <= '0;
            end
            CMD_RELEASE: begin
                r_res_slot  <= r_entry;
                r_res_fetch <= 1'b0;
                r_res_wb    <= 1'b0;
                r_res_wbsec <= '0;
                if (!r_stray && r_valid[w_rel] && r_busy[w_rel] && r_nz[w_rel]) begin
                    r_res_st <= ST_HANDED;
                end else begin
                    r_res_st <= ST_RELEASED;
                end
            end
            default: ;
        endcase

        if (i_cmd == CMD_PUSH) begin
            r_o_st    <= r_res_st;
            r_o_slot  <= r_res_slot;
            r_o_fetch <= r_res_fetch;
            r_o_wb    <= r_res_wb;
            r_o_wbsec <= r_res_wbsec;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
            r_used  <= '0;
            r_busy  <= '0;
            r_nz    <= '0;
            r_hand  <= '0;
            r_ov    <= 1'b0;
        end else begin
            case (i_cmd)
                CMD_HIT: r_busy[r_idx] <= 1'b1;
                CMD_FILL: begin
                    r_valid[r_empty_idx] <= 1'b1;
                    r_busy[r_empty_idx]  <= 1'b1;
                    r_dirty[r_empty_idx] <= 1'b0;
                end
                CMD_SWEEP: begin
                    // the hand stays on a victim until the eviction
                    if (!(w_avail && !r_used[r_hand])) begin
                        if (w_avail) begin
                            r_used[r_hand] <= 1'b0;
                        end
                        r_hand <= w_hand_inc;
                    end
                end
                CMD_EVICT: begin
                    r_dirty[r_hand] <= 1'b0;
                    r_busy[r_hand]  <= 1'b1;
                    r_hand          <= w_hand_inc;
                end
                CMD_BLOCK: r_nz[r_idx] <= 1'b1;
                CMD_RELEASE: begin
                    if (!r_stray && r_valid[w_rel] && r_busy[w_rel]) begin
                        if (r_wr) begin
                            r_dirty[w_rel] <= 1'b1;
                        end
                        if (r_nz[w_rel]) begin
                            r_nz[w_rel] <= (w_wc_cur != WC_W'(1));
                        end else begin
                            r_busy[w_rel] <= 1'b0;
                            r_used[w_rel] <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase

            if (i_cmd == CMD_PUSH) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_ov;
    assign o_status           = r_o_st;
    assign o_slot             = r_o_slot;
    assign o_need_fetch       = r_o_fetch;
    assign o_need_writeback   = r_o_wb;
    assign o_writeback_sector = r_o_wbsec;
endmodule
